/* rtl/core/ece_pkg.sv */
package ece_pkg;

   // Fixed-point layout of progress and curve factor.
   localparam int FRAC_W     = 24;
   localparam int PROG_W     = 25;
   localparam int FACT_W     = 27;
   localparam int CORDIC_W   = 28;
   localparam int ROOT_ACC_W = 50;
   localparam int DIV_STEPS  = 25;
   localparam int ITER_STEPS = 25;
   localparam int CORDIC_STEPS = 24;

   localparam logic [PROG_W-1:0] Q_ONE       = 25'h1000000;
   localparam logic [PROG_W-1:0] Q_HALF      = 25'h0800000;
   localparam logic [PROG_W-1:0] HALF_PI     = 25'd26353589;
   localparam logic [PROG_W-1:0] CORDIC_GAIN = 25'd10188014;
   localparam logic [26:0]       BACK_S      = 27'd28547775;
   localparam logic [PROG_W:0]   BACK_S1     = 26'd45324991;

   typedef enum logic [2:0] {
      OP_CIRC_IO  = 3'd0,
      OP_SINE_OUT = 3'd1,
      OP_SINE_IN  = 3'd2,
      OP_QUAD_IO  = 3'd3,
      OP_BACK_IN  = 3'd4
   } op_type;

   function automatic logic [PROG_W-1:0] atan_q24(input logic [4:0] idx);
      logic [PROG_W-1:0] val;
      case (idx)
         5'd0:    val = 25'd13176795;
         5'd1:    val = 25'd7778716;
         5'd2:    val = 25'd4110060;
         5'd3:    val = 25'd2086331;
         5'd4:    val = 25'd1047214;
         5'd5:    val = 25'd524117;
         5'd6:    val = 25'd262123;
         5'd7:    val = 25'd131069;
         5'd8:    val = 25'd65536;
         5'd9:    val = 25'd32768;
         5'd10:   val = 25'd16384;
         5'd11:   val = 25'd8192;
         5'd12:   val = 25'd4096;
         5'd13:   val = 25'd2048;
         5'd14:   val = 25'd1024;
         5'd15:   val = 25'd512;
         5'd16:   val = 25'd256;
         5'd17:   val = 25'd128;
         5'd18:   val = 25'd64;
         5'd19:   val = 25'd32;
         5'd20:   val = 25'd16;
         5'd21:   val = 25'd8;
         5'd22:   val = 25'd4;
         5'd23:   val = 25'd2;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/core/ece_req_if.sv */
interface ece_req_if #(
   parameter int VALUE_WIDTH = 32,
   parameter int TIME_WIDTH  = 16
);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    op;
   logic [TIME_WIDTH-1:0]         elapsed;
   logic [TIME_WIDTH-1:0]         duration;
   logic signed [VALUE_WIDTH-1:0] start_pos;
   logic signed [VALUE_WIDTH-1:0] change;

   modport source (output valid, op, elapsed, duration, start_pos, change, input ready);
   modport sink   (input valid, op, elapsed, duration, start_pos, change, output ready);
endinterface

/* rtl/core/ece_rsp_if.sv */
interface ece_rsp_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] position;
   logic                          saturated;
   logic                          zero_duration;

   modport source (output valid, position, saturated, zero_duration, input ready);
   modport sink   (input valid, position, saturated, zero_duration, output ready);
endinterface

/* rtl/core/easing_curve_evaluator_core.sv */
// Easing curve evaluator: one eased tween position per item, b + c * f(t/d), for five
// Penner curves. The core is a fixed pipeline of 56 register stages and accepts one item
// in every cycle while the result side takes them; most of the stages are the 25-stage
// progress divider followed by the 25-stage square root and CORDIC section. When
// the result side stalls, the whole pipeline holds and req.ready drops in the same cycle.
module easing_curve_evaluator_core #(
   parameter int VALUE_WIDTH = 32,
   parameter int TIME_WIDTH  = 16
) (
   input  logic       clock,
   input  logic       reset,
   ece_req_if.sink    req,
   ece_rsp_if.source  rsp
);

   localparam int VW     = VALUE_WIDTH;
   localparam int TW     = TIME_WIDTH;
   localparam int PW     = ece_pkg::PROG_W;
   localparam int FW     = ece_pkg::FACT_W;
   localparam int CW     = ece_pkg::CORDIC_W;
   localparam int SW     = ece_pkg::ROOT_ACC_W;
   localparam int DN     = ece_pkg::DIV_STEPS;
   localparam int IN     = ece_pkg::ITER_STEPS;
   localparam int PROD_W = VW + FW;
   localparam int RND_W  = PROD_W - ece_pkg::FRAC_W;
   localparam int SUM_W  = VW + 4;
   localparam logic signed [SUM_W-1:0] VMAX = {{(SUM_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] VMIN = ~VMAX;

   typedef struct packed {
      logic                 vld;
      logic [2:0]           op;
      logic                 zero;
      logic signed [VW-1:0] b;
      logic signed [VW-1:0] c;
   } carry_type;

   logic adv;

   // Input stage.
   carry_type    s0_ff;
   logic [TW-1:0] s0_t_ff, s0_d_ff;

   // Progress divider, one quotient bit per stage.
   carry_type       dv_c_ff [DN];
   logic [TW:0]     dv_r_ff [DN];
   logic [TW:0]     dv_r_in [DN];
   logic [TW-1:0]   dv_d_ff [DN];
   logic [PW-1:0]   dv_q_ff [DN];
   logic [PW-1:0]   dv_q_in [DN];

   // Stage A.
   carry_type              sa_c_ff;
   logic [PW-1:0]          sa_ang_ff, sa_q_ff, sa_quad_ff, sa_pp_ff;
   logic                   sa_lt_ff;
   logic signed [26:0]     sa_lin_ff;
   logic [PW-1:0]          sa_ang_in, sa_q_in, sa_quad_in, sa_pp_in;
   logic                   sa_lt_in;
   logic signed [26:0]     sa_lin_in;

   // Stage B.
   carry_type              sb_c_ff;
   logic [SW-1:0]          sb_rad_ff, sb_rad_in;
   logic signed [FW-1:0]   sb_fe_ff, sb_fe_in;
   logic [PW-1:0]          sb_ang_ff;
   logic                   sb_lt_ff;

   // Square root and CORDIC iterations.
   carry_type              it_c_ff   [IN];
   logic [SW-1:0]          it_v_ff   [IN];
   logic [SW-1:0]          it_v_in   [IN];
   logic [SW-1:0]          it_res_ff [IN];
   logic [SW-1:0]          it_res_in [IN];
   logic signed [CW-1:0]   it_x_ff   [IN];
   logic signed [CW-1:0]   it_x_in   [IN];
   logic signed [CW-1:0]   it_y_ff   [IN];
   logic signed [CW-1:0]   it_y_in   [IN];
   logic signed [CW-1:0]   it_z_ff   [IN];
   logic signed [CW-1:0]   it_z_in   [IN];
   logic signed [FW-1:0]   it_fe_ff  [IN];
   logic                   it_lt_ff  [IN];

   // Factor, product and output stages.
   carry_type              sc_c_ff, sd_c_ff;
   logic signed [FW-1:0]   sc_f_ff, sc_f_in;
   logic signed [PROD_W-1:0] sd_prod_ff;
   logic                   out_vld_ff;
   logic signed [VW-1:0]   out_pos_ff, out_pos_in;
   logic                   out_sat_ff, out_sat_in, out_zero_ff;

   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   // Divider steps: the first stage only takes out the integer bit (t equals d).
   always_comb begin
      logic [TW:0]   pr;
      logic [TW:0]   r2;
      logic [TW-1:0] pd;
      logic [PW-1:0] pq;
      logic          ge;
      for (int k = 0; k < DN; k++) begin
         pr = (k == 0) ? {1'b0, s0_t_ff} : dv_r_ff[(k == 0) ? 0 : k-1];
         pd = (k == 0) ? s0_d_ff : dv_d_ff[(k == 0) ? 0 : k-1];
         pq = (k == 0) ? '0 : dv_q_ff[(k == 0) ? 0 : k-1];
         r2 = (k == 0) ? pr : {pr[TW-1:0], 1'b0};
         ge = r2 >= {1'b0, pd};
         dv_r_in[k] = ge ? r2 - {1'b0, pd} : r2;
         dv_q_in[k] = {pq[PW-2:0], ge};
      end
   end

   // Stage A: angle, circle argument, quadratic curve and the back-curve terms.
   always_comb begin
      logic [PW-1:0]   p;
      logic [PW-1:0]   v;
      logic [2*PW-1:0] m_ang, m_vv, m_lin, m_pp;
      logic [PW-1:0]   vv;
      p          = dv_q_ff[DN-1];
      sa_lt_in   = p < ece_pkg::Q_HALF;
      v          = sa_lt_in ? p : ece_pkg::Q_ONE - p;
      sa_q_in    = {v[PW-2:0], 1'b0};
      m_ang      = (2*PW)'(p) * (2*PW)'(ece_pkg::HALF_PI);
      sa_ang_in  = m_ang[PW+23:24];
      m_vv       = (2*PW)'(v) * (2*PW)'(v);
      vv         = m_vv[PW+22:23];
      sa_quad_in = sa_lt_in ? vv : ece_pkg::Q_ONE - vv;
      m_lin      = (2*PW)'(ece_pkg::BACK_S1) * (2*PW)'(p);
      sa_lin_in  = $signed({1'b0, m_lin[PW+24:24]}) - $signed(ece_pkg::BACK_S);
      m_pp       = (2*PW)'(p) * (2*PW)'(p);
      sa_pp_in   = m_pp[PW+23:24];
   end

   // Stage B: radicand for the circle curve and the back-curve product.
   always_comb begin
      logic [2*PW-1:0]    m_sq;
      logic [PW-1:0]      diff;
      logic signed [52:0] m_back;
      m_sq      = (2*PW)'(sa_q_ff) * (2*PW)'(sa_q_ff);
      diff      = ece_pkg::Q_ONE - m_sq[PW+23:24];
      sb_rad_in = {1'b0, diff, 24'b0};
      m_back    = $signed({1'b0, sa_pp_ff}) * sa_lin_ff;
      if (sa_c_ff.op == ece_pkg::OP_QUAD_IO) begin
         sb_fe_in = $signed({2'b0, sa_quad_ff});
      end else begin
         sb_fe_in = m_back[FW+23:24];
      end
   end

   // One bit-by-bit root step per stage, and one CORDIC rotation in each stage but the last.
   always_comb begin
      logic [SW-1:0]        pv, pres, bitv, tst;
      logic signed [CW-1:0] px, py, pz, atv;
      for (int k = 0; k < IN; k++) begin
         if (k == 0) begin
            pv   = sb_rad_ff;
            pres = '0;
            px   = $signed({{(CW-PW){1'b0}}, ece_pkg::CORDIC_GAIN});
            py   = '0;
            pz   = $signed({{(CW-PW){1'b0}}, sb_ang_ff});
         end else begin
            pv   = it_v_ff[(k == 0) ? 0 : k-1];
            pres = it_res_ff[(k == 0) ? 0 : k-1];
            px   = it_x_ff[(k == 0) ? 0 : k-1];
            py   = it_y_ff[(k == 0) ? 0 : k-1];
            pz   = it_z_ff[(k == 0) ? 0 : k-1];
         end
         bitv = SW'(1) << (2*(IN-1) - 2*k);
         tst  = pres + bitv;
         if (pv >= tst) begin
            it_v_in[k]   = pv - tst;
            it_res_in[k] = (pres >> 1) + bitv;
         end else begin
            it_v_in[k]   = pv;
            it_res_in[k] = pres >> 1;
         end
         atv = $signed({{(CW-PW){1'b0}}, ece_pkg::atan_q24(5'(k))});
         if (k >= ece_pkg::CORDIC_STEPS) begin
            it_x_in[k] = px;
            it_y_in[k] = py;
            it_z_in[k] = pz;
         end else if (!pz[CW-1]) begin
            it_x_in[k] = px - (py >>> k);
            it_y_in[k] = py + (px >>> k);
            it_z_in[k] = pz - atv;
         end else begin
            it_x_in[k] = px + (py >>> k);
            it_y_in[k] = py - (px >>> k);
            it_z_in[k] = pz + atv;
         end
      end
   end

   // Stage C: pick the curve factor.
   always_comb begin
      logic signed [FW-1:0] root, one;
      root = $signed(FW'(it_res_ff[IN-1][PW-1:0]));
      one  = $signed(FW'(ece_pkg::Q_ONE));
      case (it_c_ff[IN-1].op)
         ece_pkg::OP_CIRC_IO:  sc_f_in = it_lt_ff[IN-1] ? (one - root) >>> 1
                                                        : (one + root) >>> 1;
         ece_pkg::OP_SINE_OUT: sc_f_in = FW'(it_y_ff[IN-1]);
         ece_pkg::OP_SINE_IN:  sc_f_in = one - FW'(it_x_ff[IN-1]);
         ece_pkg::OP_QUAD_IO,
         ece_pkg::OP_BACK_IN:  sc_f_in = it_fe_ff[IN-1];
         default:              sc_f_in = '0;
      endcase
   end

   // Output stage: round c*f to nearest (or take c whole for zero duration), add start, clip.
   always_comb begin
      logic signed [PROD_W-1:0] rp;
      logic signed [SUM_W-1:0]  sum;
      rp = sd_prod_ff + $signed(PROD_W'(ece_pkg::Q_HALF));
      if (sd_c_ff.zero) begin
         sum = SUM_W'(sd_c_ff.b) + SUM_W'(sd_c_ff.c);
      end else begin
         sum = SUM_W'(sd_c_ff.b) + SUM_W'($signed(rp[PROD_W-1:ece_pkg::FRAC_W]));
      end
      if (sum > VMAX) begin
         out_pos_in = VMAX[VW-1:0];
         out_sat_in = 1'b1;
      end else if (sum < VMIN) begin
         out_pos_in = VMIN[VW-1:0];
         out_sat_in = 1'b1;
      end else begin
         out_pos_in = sum[VW-1:0];
         out_sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld <= 1'b0;
         for (int k = 0; k < DN; k++) begin
            dv_c_ff[k].vld <= 1'b0;
         end
         sa_c_ff.vld <= 1'b0;
         sb_c_ff.vld <= 1'b0;
         for (int k = 0; k < IN; k++) begin
            it_c_ff[k].vld <= 1'b0;
         end
         sc_c_ff.vld <= 1'b0;
         sd_c_ff.vld <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else if (adv) begin
         s0_ff.vld  <= req.valid;
         s0_ff.op   <= req.op;
         s0_ff.zero <= req.duration == '0;
         s0_ff.b    <= req.start_pos;
         s0_ff.c    <= req.change;
         s0_t_ff    <= (req.elapsed > req.duration) ? req.duration : req.elapsed;
         s0_d_ff    <= req.duration;
         for (int k = 0; k < DN; k++) begin
            dv_c_ff[k] <= (k == 0) ? s0_ff : dv_c_ff[(k == 0) ? 0 : k-1];
            dv_d_ff[k] <= (k == 0) ? s0_d_ff : dv_d_ff[(k == 0) ? 0 : k-1];
            dv_r_ff[k] <= dv_r_in[k];
            dv_q_ff[k] <= dv_q_in[k];
         end
         sa_c_ff    <= dv_c_ff[DN-1];
         sa_ang_ff  <= sa_ang_in;
         sa_q_ff    <= sa_q_in;
         sa_lt_ff   <= sa_lt_in;
         sa_quad_ff <= sa_quad_in;
         sa_pp_ff   <= sa_pp_in;
         sa_lin_ff  <= sa_lin_in;
         sb_c_ff    <= sa_c_ff;
         sb_rad_ff  <= sb_rad_in;
         sb_fe_ff   <= sb_fe_in;
         sb_ang_ff  <= sa_ang_ff;
         sb_lt_ff   <= sa_lt_ff;
         for (int k = 0; k < IN; k++) begin
            it_c_ff[k]   <= (k == 0) ? sb_c_ff : it_c_ff[(k == 0) ? 0 : k-1];
            it_fe_ff[k]  <= (k == 0) ? sb_fe_ff : it_fe_ff[(k == 0) ? 0 : k-1];
            it_lt_ff[k]  <= (k == 0) ? sb_lt_ff : it_lt_ff[(k == 0) ? 0 : k-1];
            it_v_ff[k]   <= it_v_in[k];
            it_res_ff[k] <= it_res_in[k];
            it_x_ff[k]   <= it_x_in[k];
            it_y_ff[k]   <= it_y_in[k];
            it_z_ff[k]   <= it_z_in[k];
         end
         sc_c_ff     <= it_c_ff[IN-1];
         sc_f_ff     <= sc_f_in;
         sd_c_ff     <= sc_c_ff;
         sd_prod_ff  <= PROD_W'(sc_c_ff.c) * PROD_W'(sc_f_ff);
         out_vld_ff  <= sd_c_ff.vld;
         out_pos_ff  <= out_pos_in;
         out_sat_ff  <= out_sat_in;
         out_zero_ff <= sd_c_ff.zero;
      end
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.position      = out_pos_ff;
   assign rsp.saturated     = out_sat_ff;
   assign rsp.zero_duration = out_zero_ff;

endmodule

/* rtl/core/ece_checker.sv */
module ece_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [VALUE_WIDTH-1:0] rsp_position,
   input logic                          rsp_saturated
);

   localparam logic signed [VALUE_WIDTH-1:0] PMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] PMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position))
      else $error("result changed while stalled");

   // An empty output register never blocks the input side.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input not ready with output free");

   // A clipped result sits at one end of the range.
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_position == PMAX || rsp_position == PMIN)
      else $error("saturated result not at a rail");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind easing_curve_evaluator_core ece_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_ece_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_position  (rsp.position),
   .rsp_saturated (rsp.saturated)
);
